### hdl/mlpf_pkg.sv
package mlpf_pkg;

  // Default sizes of the queue.
  localparam int NUM_LEVELS_DEF = 4;
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Width of the APB address: two word slots, byte addressed.
  localparam int PADDR_W = 3;

  // Register word indexes on the configuration port.
  localparam logic REG_GUARD_VALUE = 1'b0;

  // Operation codes carried in kind.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

### hdl/mlpf_ctrl.sv
module mlpf_ctrl
  import mlpf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_READ;
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_READ: cmd.read = 1'b1;
      ST_DONE: cmd.load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

### hdl/mlpf_dpath.sv
module mlpf_dpath
  import mlpf_pkg::*;
#(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF,
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int GW        = (DATA_WIDTH < 32) ? DATA_WIDTH : 32
)(
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic [GW-1:0] guard,
  input  logic          kind,
  input  logic [31:0]   item_value,
  input  logic [1:0]    level,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    status,
  output logic [31:0]   front_value,
  output logic          front_valid
);

  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MD = NUM_LEVELS * DEPTH;
  localparam int AW = (MD > 1) ? $clog2(MD) : 1;

  logic [DATA_WIDTH-1:0] mem [MD];

  logic [HW-1:0] head [NUM_LEVELS];
  logic [CW-1:0] len  [NUM_LEVELS];
  logic [CW-1:0] total;

  logic          op_kind;
  logic [GW-1:0] op_value;
  logic [LW-1:0] op_level;

  logic [1:0]            res_status;
  logic                  res_valid;
  logic [DATA_WIDTH-1:0] rd_data;

  // Most urgent non-empty level.
  logic [LW-1:0] urg;
  logic          any;

  always_comb begin
    urg = '0;
    any = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (len[i] != '0) begin
        urg = LW'(i);
        any = 1'b1;
      end
    end
  end

  logic          is_full;
  logic          do_enq;
  logic          do_deq;
  logic [CW:0]   slot_sum;
  logic [HW-1:0] slot;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [HW-1:0] head_inc;

  assign is_full  = (total == CW'(DEPTH));
  assign do_enq   = cmd.exec && (op_kind == OP_ENQUEUE) && !is_full;
  assign do_deq   = cmd.exec && (op_kind == OP_DEQUEUE) && any;
  assign slot_sum = (CW+1)'(head[op_level]) + (CW+1)'(len[op_level]);
  assign slot     = (slot_sum >= (CW+1)'(DEPTH)) ? HW'(slot_sum - (CW+1)'(DEPTH))
                                                 : HW'(slot_sum);
  assign wr_addr  = AW'(32'(op_level) * DEPTH + 32'(slot));
  assign rd_addr  = AW'(32'(urg) * DEPTH + 32'(head[urg]));
  assign head_inc = (head[urg] == HW'(DEPTH - 1)) ? '0 : head[urg] + 1'b1;

  assign sts.out_busy = out_valid && out_stall;

  // Input capture; an out-of-range level saturates to the last level.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind  <= kind;
      op_value <= item_value[GW-1:0];
      if (32'(level) >= NUM_LEVELS) begin
        op_level <= LW'(NUM_LEVELS - 1);
      end else begin
        op_level <= LW'(level);
      end
    end
  end

  // Queue bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        len[i]  <= '0;
      end
    end else if (do_enq) begin
      len[op_level] <= len[op_level] + 1'b1;
      total         <= total + 1'b1;
    end else if (do_deq) begin
      len[urg]  <= len[urg] - 1'b1;
      head[urg] <= head_inc;
      total     <= total - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op_kind == OP_ENQUEUE) begin
        res_status <= is_full ? STATUS_FULL : STATUS_OK;
      end else begin
        res_status <= any ? STATUS_OK : STATUS_EMPTY;
      end
    end
    if (cmd.read) begin
      res_valid <= any;
    end
  end

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wr_addr] <= DATA_WIDTH'(op_value);
    end
    if (cmd.read) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= res_status;
      front_valid <= res_valid;
      front_value <= res_valid ? 32'(rd_data[GW-1:0]) : 32'(guard);
    end
  end

endmodule

### hdl/multilevel_priority_fifo.sv
// Multilevel priority FIFO. NUM_LEVELS priority levels share one element store,
// each level owning a circular region of DEPTH slots, with a single capacity
// limit of DEPTH items in total across all levels. An input beat with kind 0
// enqueues item_value at the tail of its level (status 1 when the queue
// already holds DEPTH items); kind 1 removes the head of the lowest-numbered
// non-empty level, level 0 being the most urgent (status 2 when empty).
// Every input beat gives exactly one output beat, which reports the front item
// after the operation, or the guard_value register with front_valid low when
// nothing is held. The beat is captured at the edge that accepts it; its result
// then passes through the queue update, the registered read of the element
// store and the load of the output register, which waits while the output
// register still holds a stalled result. The controller then returns to idle,
// so a new beat is taken only once the last one is loaded; the single read port
// of the store and the controller's one-item-at-a-time sequence set this. While
// a result waits in the output register the next beat is still accepted and
// processed up to its load. guard_value sits at byte address 0 of the APB port.
module multilevel_priority_fifo
  import mlpf_pkg::*;
#(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF,
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
  input  logic               clk,
  input  logic               rst,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [31:0]        item_value,
  input  logic [1:0]         level,
  // Output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [31:0]        front_value,
  output logic               front_valid,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // The guard value is held only as wide as the data path keeps it.
  localparam int GW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  logic [GW-1:0] guard;
  logic          reg_hit;
  cmd_t          cmd;
  sts_t          sts;

  // Word index selects the register; the low address bits are byte lanes.
  assign reg_hit = (paddr[PADDR_W-1] == REG_GUARD_VALUE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      guard <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      guard <= pwdata[GW-1:0];
    end
  end

  // Reads of the unused slot return zero.
  assign prdata = reg_hit ? 32'(guard) : 32'd0;

  mlpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlpf_dpath #(
    .NUM_LEVELS (NUM_LEVELS),
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .guard       (guard),
    .kind        (kind),
    .item_value  (item_value),
    .level       (level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .front_value (front_value),
    .front_valid (front_valid)
  );

endmodule
